// ===== rtl/frc_pkg.sv =====
`default_nettype none

package frc_pkg;

  localparam logic [7:0] PayloadStart = 8'd3;
  localparam logic [7:0] SumEnd = 8'd250;
  localparam logic [7:0] ChecksumHi = 8'd250;
  localparam logic [7:0] ChecksumLo = 8'd251;
  localparam logic [7:0] LastPos = 8'd255;
  localparam logic [7:0] TypePos = 8'd0;
  localparam logic [7:0] LengthHi = 8'd1;
  localparam logic [7:0] LengthLo = 8'd2;
  localparam logic [15:0] PayloadMax = 16'd247;

  localparam logic KindData = 1'b0;
  localparam logic KindVerdict = 1'b1;

  typedef struct packed {
    logic [7:0] frame_byte;
  } frc_in_t;

  typedef struct packed {
    logic kind;
    logic [7:0] data_byte;
    logic [7:0] frame_type;
    logic [15:0] payload_length;
    logic [31:0] stamp;
    logic checksum_ok;
    logic length_error;
  } frc_result_t;

endpackage

`default_nettype wire

// ===== rtl/frc_stream_if.sv =====
`default_nettype none

interface frc_stream_if #(
  parameter type payload_t = logic [7:0]
) ();
  logic valid;
  logic ready;
  payload_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

`default_nettype wire

// ===== rtl/frc_in_stage.sv =====
`default_nettype none

module frc_in_stage (
  input  wire logic clk,
  input  wire logic rst,
  frc_stream_if.sink frames,
  input  wire logic go,
  output logic valid,
  output logic [7:0] frame_byte
);

  assign frames.ready = !valid || go;

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (frames.ready) begin
      valid <= frames.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (frames.valid && frames.ready) begin
      frame_byte <= frames.data.frame_byte;
    end
  end

endmodule

`default_nettype wire

// ===== rtl/frc_frame_core.sv =====
`default_nettype none

module frc_frame_core (
  input  wire logic clk,
  input  wire logic rst,
  input  wire logic take,
  input  wire logic [7:0] frame_byte,
  output logic emit,
  output frc_pkg::frc_result_t result
);

  logic [7:0] position;
  logic [15:0] running_sum;
  logic [7:0] held_type;
  logic [15:0] held_length;
  logic [15:0] held_checksum;
  logic [31:0] held_stamp;

  logic [15:0] running_sum_next;
  logic [7:0] held_type_next;
  logic [15:0] held_length_next;
  logic [15:0] held_checksum_next;
  logic [31:0] held_stamp_next;
  logic [7:0] payload_index;

  assign payload_index = position - frc_pkg::PayloadStart;

  always_comb begin
    running_sum_next = running_sum;
    held_type_next = held_type;
    held_length_next = held_length;
    held_checksum_next = held_checksum;
    held_stamp_next = held_stamp;
    emit = 1'b0;
    result = '0;

    if (position == frc_pkg::TypePos) begin
      running_sum_next = {8'd0, frame_byte};
    end else if (position < frc_pkg::SumEnd) begin
      running_sum_next = running_sum + {8'd0, frame_byte};
    end

    if (position == frc_pkg::TypePos) begin
      held_type_next = frame_byte;
    end else if (position == frc_pkg::LengthHi) begin
      held_length_next = {frame_byte, 8'd0};
    end else if (position == frc_pkg::LengthLo) begin
      held_length_next = {held_length[15:8], frame_byte};
    end else if (position < frc_pkg::SumEnd) begin
      // The payload window ends at the checksum, so at most 247 bytes pass.
      if ({8'd0, payload_index} < held_length) begin
        emit = 1'b1;
        result.kind = frc_pkg::KindData;
        result.data_byte = frame_byte;
      end
    end else if (position == frc_pkg::ChecksumHi) begin
      held_checksum_next = {frame_byte, 8'd0};
    end else if (position == frc_pkg::ChecksumLo) begin
      held_checksum_next = {held_checksum[15:8], frame_byte};
    end else begin
      held_stamp_next = {held_stamp[23:0], frame_byte};
      if (position == frc_pkg::LastPos) begin
        emit = 1'b1;
        result.kind = frc_pkg::KindVerdict;
        result.frame_type = held_type;
        result.payload_length = held_length;
        result.stamp = held_stamp_next;
        result.checksum_ok = (~running_sum == held_checksum);
        result.length_error = (held_length > frc_pkg::PayloadMax);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      position <= '0;
      running_sum <= '0;
      held_type <= '0;
      held_length <= '0;
      held_checksum <= '0;
      held_stamp <= '0;
    end else if (take) begin
      position <= position + 8'd1;
      running_sum <= running_sum_next;
      held_type <= held_type_next;
      held_length <= held_length_next;
      held_checksum <= held_checksum_next;
      held_stamp <= held_stamp_next;
    end
  end

endmodule

`default_nettype wire

// ===== rtl/frc_out_stage.sv =====
`default_nettype none

module frc_out_stage (
  input  wire logic clk,
  input  wire logic rst,
  input  wire logic load,
  input  wire frc_pkg::frc_result_t result,
  output logic room,
  frc_stream_if.source results
);

  assign room = !results.valid || results.ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      results.valid <= 1'b0;
    end else if (load) begin
      results.valid <= 1'b1;
    end else if (results.ready) begin
      results.valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      results.data <= result;
    end
  end

endmodule

`default_nettype wire

// ===== rtl/frame_receive_checker.sv =====
`default_nettype none

// Checks fixed 256-byte frames arriving one byte per item and produces one result per
// payload byte plus one verdict item after the last byte of each frame. A byte can be
// accepted every cycle; each byte passes through an input register and the frame
// logic into a result register. The input stalls only when a byte that produces a
// result finds the result register still held by the receiver. Bytes of the header
// and checksum, payload bytes beyond the length and timestamp bytes before the last
// produce no result. The first byte after reset is taken as the start of a frame.
module frame_receive_checker (
  input  wire logic clk,
  input  wire logic rst,
  frc_stream_if.sink frames,
  frc_stream_if.source results
);

  logic s1_valid;
  logic [7:0] s1_byte;
  logic emit;
  logic room;
  logic go;
  frc_pkg::frc_result_t result;

  assign go = s1_valid && (!emit || room);

  frc_in_stage u_in_stage (
    .clk(clk),
    .rst(rst),
    .frames(frames),
    .go(go),
    .valid(s1_valid),
    .frame_byte(s1_byte)
  );

  frc_frame_core u_frame_core (
    .clk(clk),
    .rst(rst),
    .take(go),
    .frame_byte(s1_byte),
    .emit(emit),
    .result(result)
  );

  frc_out_stage u_out_stage (
    .clk(clk),
    .rst(rst),
    .load(go && emit),
    .result(result),
    .room(room),
    .results(results)
  );

endmodule

`default_nettype wire

// ===== rtl/frc_checker.sv =====
`default_nettype none

module frc_checker (
  input wire logic clk,
  input wire logic rst,
  input wire logic res_valid,
  input wire logic res_ready,
  input wire frc_pkg::frc_result_t res_data
);

  a_stall_hold: assert property (@(posedge clk) disable iff (rst)
    res_valid && !res_ready |=> res_valid && $stable(res_data))
    else $error("Result changed while stalled.");

  a_reset_idle: assert property (@(posedge clk)
    !rst && $past(rst) |-> !res_valid)
    else $error("Result valid right after reset.");

  a_data_clean: assert property (@(posedge clk) disable iff (rst)
    res_valid && res_data.kind == frc_pkg::KindData |->
      res_data.frame_type == 8'd0 && res_data.payload_length == 16'd0 &&
      res_data.stamp == 32'd0 && !res_data.checksum_ok && !res_data.length_error)
    else $error("Data item carries verdict fields.");

  a_verdict_clean: assert property (@(posedge clk) disable iff (rst)
    res_valid && res_data.kind == frc_pkg::KindVerdict |-> res_data.data_byte == 8'd0)
    else $error("Verdict item carries a data byte.");

  a_length_flag: assert property (@(posedge clk) disable iff (rst)
    res_valid && res_data.kind == frc_pkg::KindVerdict |->
      res_data.length_error == (res_data.payload_length > frc_pkg::PayloadMax))
    else $error("Length error flag disagrees with length.");

endmodule

bind frame_receive_checker frc_checker u_frc_checker (
  .clk(clk),
  .rst(rst),
  .res_valid(results.valid),
  .res_ready(results.ready),
  .res_data(results.data)
);

`default_nettype wire

// ===== sim/frame_receive_checker_test.sv =====
`timescale 1ns / 1ps

module frame_receive_checker_test;

  localparam int WatchdogLimit = 3000;
  localparam int HoldCycles = 400;

  class frame_scoreboard;
    logic [7:0] next_pos = '0;
    logic [15:0] byte_sum = '0;
    logic [7:0] type_q = '0;
    logic [15:0] length_q = '0;
    logic [15:0] checksum_q = '0;
    logic [31:0] stamp_q = '0;
    frc_pkg::frc_result_t pending[$];
    int mismatches = 0;
    int data_seen = 0;
    int verdicts_seen = 0;
    int bad_sum_seen = 0;
    int long_seen = 0;

    task note_byte(input logic [7:0] b);
      frc_pkg::frc_result_t r;
      logic [15:0] idx;
      r = '0;
      if (next_pos == frc_pkg::TypePos) begin
        byte_sum = {8'h00, b};
      end else if (next_pos < frc_pkg::SumEnd) begin
        byte_sum = byte_sum + {8'h00, b};
      end
      if (next_pos == frc_pkg::TypePos) begin
        type_q = b;
      end else if (next_pos == frc_pkg::LengthHi) begin
        length_q = {b, 8'h00};
      end else if (next_pos == frc_pkg::LengthLo) begin
        length_q = {length_q[15:8], b};
      end else if (next_pos < frc_pkg::SumEnd) begin
        idx = {8'h00, next_pos} - {8'h00, frc_pkg::PayloadStart};
        if (idx < length_q && idx < frc_pkg::PayloadMax) begin
          r.kind = frc_pkg::KindData;
          r.data_byte = b;
          pending.push_back(r);
        end
      end else if (next_pos == frc_pkg::ChecksumHi) begin
        checksum_q = {b, 8'h00};
      end else if (next_pos == frc_pkg::ChecksumLo) begin
        checksum_q = {checksum_q[15:8], b};
      end else begin
        stamp_q = {stamp_q[23:0], b};
        if (next_pos == frc_pkg::LastPos) begin
          r.kind = frc_pkg::KindVerdict;
          r.frame_type = type_q;
          r.payload_length = length_q;
          r.stamp = stamp_q;
          // The sum of 250 bytes never carries past bit 15, so the fold is a no-op.
          r.checksum_ok = (~byte_sum == checksum_q);
          r.length_error = (length_q > frc_pkg::PayloadMax);
          pending.push_back(r);
        end
      end
      next_pos = next_pos + 8'd1;
    endtask

    task report_mismatch(input string field, input logic [31:0] got, input logic [31:0] want);
      if (mismatches < 30) begin
        $display("Mismatch on %s: got %0h, expected %0h", field, got, want);
      end
      mismatches++;
    endtask

    task check_result(input frc_pkg::frc_result_t got);
      frc_pkg::frc_result_t want;
      if (pending.size() == 0) begin
        report_mismatch("unexpected result kind", got.kind, '0);
      end else begin
        want = pending.pop_front();
        if (want.kind == frc_pkg::KindVerdict) begin
          verdicts_seen++;
          if (!want.checksum_ok) bad_sum_seen++;
          if (want.length_error) long_seen++;
        end else begin
          data_seen++;
        end
        if (got.kind !== want.kind) report_mismatch("kind", got.kind, want.kind);
        if (got.data_byte !== want.data_byte)
          report_mismatch("data_byte", got.data_byte, want.data_byte);
        if (got.frame_type !== want.frame_type)
          report_mismatch("frame_type", got.frame_type, want.frame_type);
        if (got.payload_length !== want.payload_length)
          report_mismatch("payload_length", got.payload_length, want.payload_length);
        if (got.stamp !== want.stamp) report_mismatch("stamp", got.stamp, want.stamp);
        if (got.checksum_ok !== want.checksum_ok)
          report_mismatch("checksum_ok", got.checksum_ok, want.checksum_ok);
        if (got.length_error !== want.length_error)
          report_mismatch("length_error", got.length_error, want.length_error);
      end
    endtask
  endclass

  logic clk = 1'b0;
  logic rst = 1'b1;

  frc_stream_if #(.payload_t(frc_pkg::frc_in_t)) frames_if ();
  frc_stream_if #(.payload_t(frc_pkg::frc_result_t)) results_if ();

  frame_receive_checker i_dut (
    .clk(clk),
    .rst(rst),
    .frames(frames_if),
    .results(results_if)
  );

  frame_scoreboard sb = new();
  int send_idle_pct = 23;
  int recv_idle_pct = 83;
  logic hold_request = 1'b0;
  int hold_left = 0;
  int idle_cycles = 0;
  int frames_sent = 0;
  int bytes_sent = 0;

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  always @(posedge clk) begin
    if (hold_request) begin
      hold_left = HoldCycles;
      hold_request <= 1'b0;
    end
    if (hold_left > 0) begin
      hold_left--;
      results_if.ready <= 1'b0;
    end else begin
      results_if.ready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  always @(posedge clk) begin
    if (!rst) begin
      if (frames_if.valid && frames_if.ready) sb.note_byte(frames_if.data.frame_byte);
      if (results_if.valid && results_if.ready) sb.check_result(results_if.data);
    end
  end

  always @(posedge clk) begin
    if (!rst) begin
      if ((frames_if.valid && frames_if.ready) || (results_if.valid && results_if.ready)) begin
        idle_cycles = 0;
      end else begin
        idle_cycles++;
      end
      if (idle_cycles >= WatchdogLimit) begin
        $display("Timeout after %0d cycles without progress.", idle_cycles);
        $display("FAILURE");
        $finish;
      end
    end
  end

  task automatic send_byte(input logic [7:0] b);
    while ($urandom_range(99) < send_idle_pct) begin
      frames_if.valid <= 1'b0;
      @(posedge clk);
    end
    frames_if.valid <= 1'b1;
    frames_if.data <= b;
    do @(posedge clk); while (!frames_if.ready);
    bytes_sent++;
  endtask

  task automatic send_frame(input logic [7:0] ftype, input logic [15:0] flen,
                            input bit sum_good, input logic [31:0] fstamp, input int fill);
    logic [7:0] fb [256];
    logic [15:0] total;
    fb[frc_pkg::TypePos] = ftype;
    fb[frc_pkg::LengthHi] = flen[15:8];
    fb[frc_pkg::LengthLo] = flen[7:0];
    for (int i = frc_pkg::PayloadStart; i < frc_pkg::SumEnd; i++)
      fb[i] = (fill < 0) ? 8'($urandom) : 8'(fill);
    total = '0;
    for (int i = 0; i < frc_pkg::SumEnd; i++) total = total + {8'h00, fb[i]};
    total = ~total;
    if (!sum_good) total = total ^ (16'd1 << $urandom_range(15));
    fb[frc_pkg::ChecksumHi] = total[15:8];
    fb[frc_pkg::ChecksumLo] = total[7:0];
    fb[252] = fstamp[31:24];
    fb[253] = fstamp[23:16];
    fb[254] = fstamp[15:8];
    fb[frc_pkg::LastPos] = fstamp[7:0];
    for (int i = 0; i < 256; i++) send_byte(fb[i]);
    frames_sent++;
  endtask

  task automatic send_random_frame();
    logic [15:0] flen;
    if ($urandom_range(5) == 0) begin
      flen = 16'($urandom_range(65535, 248));
    end else begin
      flen = 16'($urandom_range(247));
    end
    send_frame(8'($urandom), flen, $urandom_range(7) != 0, $urandom, -1);
  endtask

  task automatic wait_results_drained();
    frames_if.valid <= 1'b0;
    do @(posedge clk); while (sb.pending.size() != 0);
  endtask

  initial begin
    frames_if.valid = 1'b0;
    frames_if.data = '0;
    results_if.ready = 1'b0;
    repeat (5) @(posedge clk);
    rst <= 1'b0;

    send_idle_pct = 23;
    recv_idle_pct = 83;
    send_frame(8'h00, 16'd0, 1'b1, 32'h0000_0000, 8'h00);
    send_frame(8'h5A, 16'd248, 1'b0, 32'h0102_0304, -1);
    wait_results_drained();

    send_idle_pct = 83;
    recv_idle_pct = 23;
    send_frame(8'hFF, 16'd247, 1'b1, 32'hFFFF_FFFF, 8'hFF);
    send_frame(8'h81, 16'hFFFF, 1'b1, $urandom, -1);
    wait_results_drained();

    send_idle_pct = 0;
    recv_idle_pct = 0;
    hold_request <= 1'b1;
    send_random_frame();
    wait_results_drained();

    repeat (8) @(posedge clk);
    $display("Sent %0d frames in %0d bytes; checked %0d payload bytes and %0d verdicts.",
             frames_sent, bytes_sent, sb.data_seen, sb.verdicts_seen);
    $display("Verdicts with a bad checksum: %0d; with an oversized length: %0d.",
             sb.bad_sum_seen, sb.long_seen);
    if (sb.mismatches == 0 && sb.pending.size() == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
